@@ sv/max_pooling_by_pixel_sum_defines.svh @@
// Assertion helpers for the pixel-sum max pooling block.
// MPPS_ASSERT is gated off while reset is low; MPPS_ASSERT_RST also checks during reset.
// Both expect clk and arst_n in scope.
`ifndef MAX_POOLING_BY_PIXEL_SUM_DEFINES_SVH
`define MAX_POOLING_BY_PIXEL_SUM_DEFINES_SVH

`ifndef SYNTH
`define MPPS_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mpps assertion failed");
`define MPPS_ASSERT_RST(name, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("mpps reset assertion failed");
`else
`define MPPS_ASSERT(name, prop)
`define MPPS_ASSERT_RST(name, prop)
`endif

`endif

@@ sv/mpps_pkg.sv @@
package mpps_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} mpps_state_t;

	localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
	localparam logic [1:0] REG_STRIDE      = 2'd1;
	localparam logic [1:0] REG_IMAGE_ROWS  = 2'd2;
	localparam logic [1:0] REG_IMAGE_COLS  = 2'd3;

	localparam logic [2:0]  RST_WINDOW_SIZE = 3'd2;
	localparam logic [2:0]  RST_STRIDE      = 3'd2;
	localparam logic [10:0] RST_IMAGE_ROWS  = 11'd28;
	localparam logic [10:0] RST_IMAGE_COLS  = 11'd28;

	localparam logic [10:0] ROW_LIMIT = 11'd1024;

endpackage

@@ sv/max_pooling_by_pixel_sum.sv @@
// Strided max pooling by channel sum over three-channel pixels streamed in row-major order.
// Each pixel is written into a line store of MAX_WINDOW rows by MAX_COLS columns (no
// reset clear needed; a window only reads pixels of the current frame). A pixel that
// does not complete a window on the stride grid is taken in alone. A pixel that completes
// one starts a window job: the single read port of the line store
// fetches the window one pixel per cycle and a shared sum-and-compare unit keeps the
// first pixel with the largest channel sum; the result then goes to the output register,
// which may still hold the previous result while the next pixel is taken in. The handoff
// waits, and the pixel takes longer, while that previous result is not yet accepted.
// Any configuration write restarts the frame at row 0, column 0.
`include "max_pooling_by_pixel_sum_defines.svh"

module max_pooling_by_pixel_sum #(
	parameter int MAX_COLS     = 1024,
	parameter int MAX_WINDOW   = 4,
	parameter int CHANNEL_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	// chan0, chan1, chan2
	input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,

	output logic m_tvalid,
	input  logic m_tready,
	// best0, best1, best2, out_row, out_col
	output logic [((3*CHANNEL_BITS+20+7)/8)*8-1:0] m_tdata,
	output logic m_tlast,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	import mpps_pkg::*;

	localparam int CB     = CHANNEL_BITS;
	localparam int PW     = 3 * CB;
	localparam int OUT_W  = ((PW + 20 + 7) / 8) * 8;
	localparam int SW     = CB + 2;
	localparam int MW     = MAX_WINDOW;
	localparam int CW     = $clog2(MAX_COLS);
	localparam int XW     = ((CW > 11) ? CW : 11) + 1;
	localparam int SLW    = (MW > 1) ? $clog2(MW) : 1;
	localparam int WW     = $clog2(MW + 1);
	localparam int DEPTH  = MW * MAX_COLS;
	localparam int AW     = $clog2(DEPTH);

	// configuration
	logic [2:0]  ws_q;
	logic [2:0]  st_q;
	logic [10:0] rows_q;
	logic [10:0] cols_q;

	logic [WW-1:0] ws_e;
	logic [WW-1:0] ws_m1;
	logic [2:0]    st_e;
	logic [10:0]   rows_e;
	logic [XW-1:0] cols_e;

	always_comb begin
		if (ws_q == 3'd0) begin
			ws_e = WW'(1);
		end else if (5'(ws_q) > 5'(MW)) begin
			ws_e = WW'(MW);
		end else begin
			ws_e = WW'(ws_q);
		end
		ws_m1 = ws_e - WW'(1);
		st_e = (st_q == 3'd0) ? 3'd1 : st_q;
		if (rows_q == 11'd0) begin
			rows_e = 11'd1;
		end else if (rows_q > ROW_LIMIT) begin
			rows_e = ROW_LIMIT;
		end else begin
			rows_e = rows_q;
		end
		if (cols_q == 11'd0) begin
			cols_e = XW'(1);
		end else if (XW'(cols_q) > XW'(MAX_COLS)) begin
			cols_e = XW'(MAX_COLS);
		end else begin
			cols_e = XW'(cols_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= RST_WINDOW_SIZE;
			st_q   <= RST_STRIDE;
			rows_q <= RST_IMAGE_ROWS;
			cols_q <= RST_IMAGE_COLS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_SIZE: ws_q   <= cfg_data[2:0];
				REG_STRIDE:      st_q   <= cfg_data[2:0];
				REG_IMAGE_ROWS:  rows_q <= cfg_data;
				REG_IMAGE_COLS:  cols_q <= cfg_data;
			endcase
		end
	end

	// scan position, line store slot of the current row, stride phase and output index
	logic [9:0]     row_q;
	logic [CW-1:0]  col_q;
	logic [SLW-1:0] slot_q;
	logic [2:0]     rph_q;
	logic [2:0]     cph_q;
	logic [9:0]     orow_q;
	logic [9:0]     ocol_q;

	logic acc;
	logic r_ok;
	logic c_ok;
	logic hit;
	logic row_last;
	logic col_last;
	logic done_now;

	assign acc      = s_tvalid && s_tready;
	assign r_ok     = (11'(row_q) + 11'd1) >= 11'(ws_e);
	assign c_ok     = (XW'(col_q) + XW'(1)) >= XW'(ws_e);
	assign hit      = r_ok && c_ok && (rph_q == 3'd0) && (cph_q == 3'd0);
	assign row_last = (11'(row_q) + 11'd1) >= rows_e;
	assign col_last = (XW'(col_q) + XW'(1)) >= cols_e;
	// no later window origin fits in either direction
	assign done_now = ((XW'(col_q) + XW'(st_e)) >= cols_e)
		&& ((11'(row_q) + 11'(st_e)) >= rows_e);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
			rph_q  <= '0;
			cph_q  <= '0;
			orow_q <= '0;
			ocol_q <= '0;
		end else if (cfg_we) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
			rph_q  <= '0;
			cph_q  <= '0;
			orow_q <= '0;
			ocol_q <= '0;
		end else if (acc) begin
			if (col_last) begin
				col_q <= '0;
				cph_q <= '0;
				ocol_q <= '0;
				if (row_last) begin
					row_q  <= '0;
					slot_q <= '0;
					rph_q  <= '0;
					orow_q <= '0;
				end else begin
					row_q  <= row_q + 10'd1;
					slot_q <= (32'(slot_q) == MW - 1) ? '0 : slot_q + SLW'(1);
					if (r_ok) begin
						if (rph_q == st_e - 3'd1) begin
							rph_q  <= '0;
							orow_q <= orow_q + 10'd1;
						end else begin
							rph_q <= rph_q + 3'd1;
						end
					end
				end
			end else begin
				col_q <= col_q + CW'(1);
				if (c_ok) begin
					if (cph_q == st_e - 3'd1) begin
						cph_q  <= '0;
						ocol_q <= ocol_q + 10'd1;
					end else begin
						cph_q <= cph_q + 3'd1;
					end
				end
			end
		end
	end

	// sequencer
	mpps_state_t state_q;
	mpps_state_t state_d;
	logic rd_en;
	logic load_out;
	logic m_tvalid_q;

	logic [WW-1:0] kr_q;
	logic [WW-1:0] kc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && hit) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				rd_en = 1'b1;
				if (kr_q == ws_m1 && kc_q == ws_m1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	// window job
	logic [CW-1:0]  base_col_q;
	logic [SLW-1:0] rd_slot_q;
	logic [9:0]     j_row_q;
	logic [9:0]     j_col_q;
	logic           j_done_q;
	logic [4:0]     start_slot;

	always_comb begin
		start_slot = 5'(slot_q) + 5'(MW) - 5'(ws_e) + 5'd1;
		if (start_slot >= 5'(MW)) begin
			start_slot = start_slot - 5'(MW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kr_q <= '0;
			kc_q <= '0;
		end else if (acc && hit) begin
			kr_q <= '0;
			kc_q <= '0;
		end else if (rd_en) begin
			if (kc_q == ws_m1) begin
				kc_q <= '0;
				kr_q <= kr_q + WW'(1);
			end else begin
				kc_q <= kc_q + WW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && hit) begin
			base_col_q <= col_q - CW'(ws_m1);
			rd_slot_q  <= SLW'(start_slot);
			j_row_q    <= orow_q;
			j_col_q    <= ocol_q;
			j_done_q   <= done_now;
		end else if (rd_en && kc_q == ws_m1) begin
			rd_slot_q <= (32'(rd_slot_q) == MW - 1) ? '0 : rd_slot_q + SLW'(1);
		end
	end

	// line store
	logic [PW-1:0] mem [DEPTH];
	logic [PW-1:0] rd_q;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	assign waddr = AW'(slot_q) * AW'(MAX_COLS) + AW'(col_q);
	assign raddr = AW'(rd_slot_q) * AW'(MAX_COLS) + AW'(base_col_q + CW'(kc_q));

	always_ff @(posedge clk) begin
		if (acc) begin
			mem[waddr] <= s_tdata[PW-1:0];
		end
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	// shared sum-and-compare unit
	logic          rd_vld_s1;
	logic          first_s1;
	logic [SW-1:0] rd_sum;
	logic [SW-1:0] best_sum_q;
	logic [PW-1:0] best_pix_q;

	assign rd_sum = SW'(rd_q[CB-1:0]) + SW'(rd_q[2*CB-1:CB]) + SW'(rd_q[3*CB-1:2*CB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (kr_q == '0) && (kc_q == '0);
		// strict compare keeps the earliest pixel on a tie
		if (rd_vld_s1 && (first_s1 || rd_sum > best_sum_q)) begin
			best_sum_q <= rd_sum;
			best_pix_q <= rd_q;
		end
	end

	// output register
	logic [OUT_W-1:0] m_tdata_q;
	logic             m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= OUT_W'({j_col_q, j_row_q, best_pix_q});
			m_tlast_q <= j_done_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`MPPS_ASSERT(a_run_in_window, (state_q == ST_RUN) |-> (kr_q < ws_e && kc_q < ws_e))
	`MPPS_ASSERT(a_hit_starts_run, (acc && hit) |=> (state_q == ST_RUN))
	`MPPS_ASSERT(a_read_in_job, rd_vld_s1 |-> (state_q == ST_RUN || state_q == ST_DRAIN))
	`MPPS_ASSERT(a_emit_waits, (state_q == ST_EMIT && m_tvalid_q && !m_tready) |=> (state_q == ST_EMIT))
	`MPPS_ASSERT_RST(a_reset_clear, (!arst_n) |-> (!m_tvalid && state_q == ST_IDLE))

endmodule
